### sv/ddodo_pkg.sv
// Shared types, constants and tables of the differential drive odometry block.
package ddodo_pkg;

	localparam int DIV_STEPS = 26;
	localparam int CNT_W     = 5;
	localparam int ATAN_N    = 24;

	localparam logic [18:0] DIST_K      = 19'd421657;
	localparam logic [29:0] ANG_K       = 30'd683565276;
	localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL1,
		OP_MUL2,
		OP_MUL3,
		OP_SUM,
		OP_ANG,
		OP_ITER,
		OP_MULCS,
		OP_UPD
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [CNT_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic [15:0] max_speed;
		logic [15:0] wheel_radius;
		logic [15:0] chassis_length;
		logic [9:0]  poll_period_ms;
	} cfg_t;

	function automatic logic [29:0] atan_turn(input logic [CNT_W-1:0] i);
		logic [29:0] v;
		case (i)
			5'd0:    v = 30'd536870912;
			5'd1:    v = 30'd316933406;
			5'd2:    v = 30'd167458907;
			5'd3:    v = 30'd85004756;
			5'd4:    v = 30'd42667331;
			5'd5:    v = 30'd21354465;
			5'd6:    v = 30'd10680862;
			5'd7:    v = 30'd5340245;
			5'd8:    v = 30'd2670163;
			5'd9:    v = 30'd1335087;
			5'd10:   v = 30'd667544;
			5'd11:   v = 30'd333772;
			5'd12:   v = 30'd166886;
			5'd13:   v = 30'd83443;
			5'd14:   v = 30'd41722;
			5'd15:   v = 30'd20861;
			5'd16:   v = 30'd10430;
			5'd17:   v = 30'd5215;
			5'd18:   v = 30'd2608;
			5'd19:   v = 30'd1304;
			5'd20:   v = 30'd652;
			5'd21:   v = 30'd326;
			5'd22:   v = 30'd163;
			5'd23:   v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

### sv/ddodo_dp.sv
// Datapath: wheel distances, angular step divider, CORDIC and pose accumulators.
module ddodo_dp #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ddodo_pkg::cmd_t     cmd,
	input  ddodo_pkg::cfg_t     cfg,
	input  logic signed [15:0]  left_speed,
	input  logic signed [15:0]  right_speed,
	output logic signed [31:0]  x_position,
	output logic signed [31:0]  y_position,
	output logic [15:0]         heading_angle
);

	logic [14:0]        sl_q, sr_q;
	logic [40:0]        pl_q, pr_q;
	logic [11:0]        dl_q, dr_q;
	logic [12:0]        l2_q;
	logic [11:0]        diff_q;
	logic               neg_q;
	logic [25:0]        div_q;
	logic [15:0]        rem_q;
	logic signed [31:0] cx_q, cy_q;
	logic signed [33:0] cz_q;
	logic               flip_q;
	logic signed [45:0] prod_x_q, prod_y_q;
	logic [31:0]        pos_x_q, pos_y_q;
	logic [15:0]        head_q;
	logic [31:0]        xo_q, yo_q;
	logic [15:0]        ho_q;

	logic [14:0]        cl_left, cl_right;
	logic [59:0]        rl, rr;
	logic [41:0]        num;
	logic [16:0]        rem_sh;
	logic               ge;
	logic signed [31:0] xs, ys;
	logic               in_fold;
	logic [15:0]        head_fold;
	logic signed [45:0] rx, ry;
	logic [15:0]        dang;

	function automatic logic [14:0] clamp(input logic [15:0] v, input logic [15:0] mx);
		logic [14:0] r;
		if (v[15])
			r = '0;
		else if (v > mx)
			r = mx[14:0];
		else
			r = v[14:0];
		return r;
	endfunction

	always_comb begin
		cl_left   = clamp(left_speed, cfg.max_speed);
		cl_right  = clamp(right_speed, cfg.max_speed);
		rl        = pl_q * {41'd0, ddodo_pkg::DIST_K} + 60'h0000_8000_0000_0000 >> 0;
		rr        = pr_q * {41'd0, ddodo_pkg::DIST_K} + 60'h0000_8000_0000_0000 >> 0;
		num       = {30'd0, diff_q} * {12'd0, ddodo_pkg::ANG_K}
		            + {11'd0, cfg.chassis_length, 15'd0};
		rem_sh    = {rem_q, div_q[25]};
		ge        = rem_sh >= {1'b0, cfg.chassis_length};
		xs        = cx_q >>> cmd.step;
		ys        = cy_q >>> cmd.step;
		in_fold   = head_q[15] ^ head_q[14];
		head_fold = {head_q[15] ^ in_fold, head_q[14:0]};
		rx        = prod_x_q + 46'sh0000_4000_0000;
		ry        = prod_y_q + 46'sh0000_4000_0000;
		if (cfg.chassis_length == '0)
			dang = '0;
		else if (neg_q)
			dang = 16'd0 - div_q[15:0];
		else
			dang = div_q[15:0];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ddodo_pkg::OP_LOAD: begin
				sl_q <= cl_left;
				sr_q <= cl_right;
			end
			ddodo_pkg::OP_MUL1: begin
				pl_q <= {16'd0, 25'(sl_q) * 25'(cfg.poll_period_ms)};
				pr_q <= {16'd0, 25'(sr_q) * 25'(cfg.poll_period_ms)};
			end
			ddodo_pkg::OP_MUL2: begin
				pl_q <= {16'd0, pl_q[24:0]} * {25'd0, cfg.wheel_radius};
				pr_q <= {16'd0, pr_q[24:0]} * {25'd0, cfg.wheel_radius};
			end
			ddodo_pkg::OP_MUL3: begin
				dl_q <= rl[59:48];
				dr_q <= rr[59:48];
			end
			ddodo_pkg::OP_SUM: begin
				l2_q   <= {1'b0, dl_q} + {1'b0, dr_q};
				diff_q <= (dr_q >= dl_q) ? dr_q - dl_q : dl_q - dr_q;
				neg_q  <= dl_q > dr_q;
			end
			ddodo_pkg::OP_ANG: begin
				div_q  <= num[41:16];
				rem_q  <= '0;
				cx_q   <= $signed(ddodo_pkg::CORDIC_GAIN);
				cy_q   <= '0;
				cz_q   <= {{2{head_fold[15]}}, head_fold, 16'd0};
				flip_q <= in_fold;
			end
			ddodo_pkg::OP_ITER: begin
				rem_q <= ge ? 16'(rem_sh - {1'b0, cfg.chassis_length}) : rem_sh[15:0];
				div_q <= {div_q[24:0], ge};
				if (32'(cmd.step) < CORDIC_STEPS) begin
					if (!cz_q[33]) begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						cz_q <= cz_q - $signed({4'd0, ddodo_pkg::atan_turn(cmd.step)});
					end else begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						cz_q <= cz_q + $signed({4'd0, ddodo_pkg::atan_turn(cmd.step)});
					end
				end
			end
			ddodo_pkg::OP_MULCS: begin
				prod_x_q <= 46'($signed({1'b0, l2_q})) * 46'(flip_q ? -cx_q : cx_q);
				prod_y_q <= 46'($signed({1'b0, l2_q})) * 46'(flip_q ? -cy_q : cy_q);
			end
			ddodo_pkg::OP_UPD: begin
				xo_q <= pos_x_q + {{17{rx[45]}}, rx[45:31]};
				yo_q <= pos_y_q + {{17{ry[45]}}, ry[45:31]};
				ho_q <= head_q + dang;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			head_q  <= '0;
		end else if (cmd.op == ddodo_pkg::OP_UPD) begin
			pos_x_q <= pos_x_q + {{17{rx[45]}}, rx[45:31]};
			pos_y_q <= pos_y_q + {{17{ry[45]}}, ry[45:31]};
			head_q  <= head_q + dang;
		end
	end

	assign x_position    = $signed(xo_q);
	assign y_position    = $signed(yo_q);
	assign heading_angle = ho_q;

endmodule

### sv/ddodo_ctrl.sv
// Controller: sequences one word through the datapath and owns the handshakes.
module ddodo_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output ddodo_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_SUM,
		ST_ANG,
		ST_ITER,
		ST_MULCS,
		ST_UPD
	} state_t;

	state_t                      state_q;
	logic [ddodo_pkg::CNT_W-1:0] cnt_q;
	logic                        out_valid_q;
	logic                        upd_go;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign upd_go    = !out_valid_q || out_ready;

	always_comb begin
		cmd.step = cnt_q;
		case (state_q)
			ST_IDLE:  cmd.op = in_valid ? ddodo_pkg::OP_LOAD : ddodo_pkg::OP_NONE;
			ST_MUL1:  cmd.op = ddodo_pkg::OP_MUL1;
			ST_MUL2:  cmd.op = ddodo_pkg::OP_MUL2;
			ST_MUL3:  cmd.op = ddodo_pkg::OP_MUL3;
			ST_SUM:   cmd.op = ddodo_pkg::OP_SUM;
			ST_ANG:   cmd.op = ddodo_pkg::OP_ANG;
			ST_ITER:  cmd.op = ddodo_pkg::OP_ITER;
			ST_MULCS: cmd.op = ddodo_pkg::OP_MULCS;
			ST_UPD:   cmd.op = upd_go ? ddodo_pkg::OP_UPD : ddodo_pkg::OP_NONE;
			default:  cmd.op = ddodo_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_UPD && upd_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_MUL1;
				end
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_MUL3;
				ST_MUL3:  state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_ANG;
				ST_ANG: begin
					cnt_q   <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ddodo_pkg::CNT_W'(ddodo_pkg::DIV_STEPS - 1))
						state_q <= ST_MULCS;
				end
				ST_MULCS: state_q <= ST_UPD;
				ST_UPD: begin
					if (upd_go)
						state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/differential_drive_odometry.sv
// Top level: APB register file, controller and datapath of the wheel odometry.
//
//  channel | signals                                   | carries
//  in      | in_valid, in_ready                        | left_speed, right_speed
//  out     | out_valid, out_ready                      | x_position, y_position, heading_angle
//  cfg     | psel, penable, pwrite, paddr, pwdata, ... | max_speed .. poll_period_ms
//
// Each accepted word passes through five multiply and setup steps, 26 iterations
// of the radix-2 divider (the CORDIC runs in the same cycles), one multiply and
// one update.
// in_ready is high only while idle; a held result stalls only the final update.
// Reset clears the pose and loads the register defaults.
module differential_drive_odometry #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] left_speed,
	input  logic signed [15:0] right_speed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] x_position,
	output logic signed [31:0] y_position,
	output logic [15:0]        heading_angle,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic [1:0] REG_MAX_SPEED = 2'd0;
	localparam logic [1:0] REG_RADIUS    = 2'd1;
	localparam logic [1:0] REG_CHASSIS   = 2'd2;
	localparam logic [1:0] REG_PERIOD    = 2'd3;

	ddodo_pkg::cfg_t cfg_q;
	ddodo_pkg::cmd_t cmd;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed      <= 16'd3277;
			cfg_q.wheel_radius   <= 16'd0;
			cfg_q.chassis_length <= 16'd65535;
			cfg_q.poll_period_ms <= 10'd100;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_MAX_SPEED: cfg_q.max_speed      <= pwdata[15:0];
				REG_RADIUS:    cfg_q.wheel_radius   <= pwdata[15:0];
				REG_CHASSIS:   cfg_q.chassis_length <= pwdata[15:0];
				REG_PERIOD:    cfg_q.poll_period_ms <= pwdata[9:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MAX_SPEED: prdata = {16'd0, cfg_q.max_speed};
			REG_RADIUS:    prdata = {16'd0, cfg_q.wheel_radius};
			REG_CHASSIS:   prdata = {16'd0, cfg_q.chassis_length};
			REG_PERIOD:    prdata = {22'd0, cfg_q.poll_period_ms};
			default:       prdata = '0;
		endcase
	end

	ddodo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ddodo_dp #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg_q),
		.left_speed    (left_speed),
		.right_speed   (right_speed),
		.x_position    (x_position),
		.y_position    (y_position),
		.heading_angle (heading_angle)
	);

endmodule

### dv/odo_regmap_pkg.sv
`timescale 1ns / 100ps
// Register addresses of the odometry configuration port, shared by the testbench files.
package odo_regmap_pkg;

	typedef enum logic [3:0] {
		REG_MAX_SPEED      = 4'h0,
		REG_WHEEL_RADIUS   = 4'h4,
		REG_CHASSIS_LENGTH = 4'h8,
		REG_POLL_PERIOD    = 4'hC
	} reg_addr_t;

endpackage

### dv/differential_drive_odometry_checker.sv
`timescale 1ns / 100ps
// Pose predictor and result checker that watches the odometry block's ports.
module differential_drive_odometry_checker
	import odo_regmap_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] left_speed,
	input  logic signed [15:0] right_speed,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] x_position,
	input  logic signed [31:0] y_position,
	input  logic [15:0]        heading_angle,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output int                 poses_in_flight,
	output int                 mismatches
);

	localparam longint unsigned WHEEL_K   = 64'd421657;
	localparam longint unsigned TURN_K    = 64'd683565276;
	localparam longint          UNIT_GAIN = 64'sd652032874;
	localparam int              ATAN_N    = 24;

	// arctangent of 2^-i in 32-bit binary angle, entry 0 in the low bits
	localparam logic [ATAN_N*30-1:0] ATAN_TURNS = {
		30'd81,       30'd163,      30'd326,      30'd652,
		30'd1304,     30'd2608,     30'd5215,     30'd10430,
		30'd20861,    30'd41722,    30'd83443,    30'd166886,
		30'd333772,   30'd667544,   30'd1335087,  30'd2670163,
		30'd5340245,  30'd10680862, 30'd21354465, 30'd42667331,
		30'd85004756, 30'd167458907, 30'd316933406, 30'd536870912
	};

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        hdg;
	} pose_t;

	ddodo_pkg::cfg_t cfg;
	logic [31:0]     pos_x;
	logic [31:0]     pos_y;
	logic [15:0]     heading;
	pose_t           pending_poses[$];

	function automatic longint unsigned wheel_distance(input logic [15:0] raw);
		longint unsigned spd;
		spd = raw[15] ? 64'd0 : {49'd0, raw[14:0]};
		if (spd > cfg.max_speed)
			spd = cfg.max_speed;
		return (spd * cfg.poll_period_ms * cfg.wheel_radius * WHEEL_K + (64'd1 << 47)) >> 48;
	endfunction

	function automatic pose_t advance_pose(input logic [15:0] left_raw, input logic [15:0] right_raw);
		longint unsigned dl, dr, diff, den, mag;
		longint          l2, cs, sn, xs, ys, z, dx, dy;
		logic [31:0]     ang;
		logic [15:0]     dang;
		logic            flip;
		pose_t           nxt;
		dl = wheel_distance(left_raw);
		dr = wheel_distance(right_raw);
		l2 = longint'(dl + dr);
		dang = '0;
		if (cfg.chassis_length != 0) begin
			diff = (dr >= dl) ? dr - dl : dl - dr;
			den = {32'd0, cfg.chassis_length, 16'd0};
			mag = (diff * TURN_K + (den >> 1)) / den;
			dang = mag[15:0];
			if (dl > dr)
				dang = -dang;
		end
		// rotate on the heading held before this tick, folded into +-90 degrees
		ang = {heading, 16'd0};
		flip = ang[31] ^ ang[30];
		if (flip)
			ang = ang + 32'h8000_0000;
		z = longint'($signed(ang));
		cs = UNIT_GAIN;
		sn = 0;
		for (int i = 0; i < CORDIC_STEPS && i < ATAN_N; i++) begin
			xs = cs >>> i;
			ys = sn >>> i;
			if (z >= 0) begin
				cs = cs - ys;
				sn = sn + xs;
				z = z - longint'(ATAN_TURNS[i*30 +: 30]);
			end else begin
				cs = cs + ys;
				sn = sn - xs;
				z = z + longint'(ATAN_TURNS[i*30 +: 30]);
			end
		end
		if (flip) begin
			cs = -cs;
			sn = -sn;
		end
		dx = (l2 * cs + 64'sd1073741824) >>> 31;
		dy = (l2 * sn + 64'sd1073741824) >>> 31;
		pos_x = pos_x + dx[31:0];
		pos_y = pos_y + dy[31:0];
		heading = heading + dang;
		nxt.x = pos_x;
		nxt.y = pos_y;
		nxt.hdg = heading;
		return nxt;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pose_t want;
		if (!arst_n) begin
			cfg.max_speed = 16'd3277;
			cfg.wheel_radius = 16'd0;
			cfg.chassis_length = 16'd65535;
			cfg.poll_period_ms = 10'd100;
			pos_x = '0;
			pos_y = '0;
			heading = '0;
			pending_poses.delete();
			mismatches = 0;
			poses_in_flight <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_addr_t'(paddr))
					REG_MAX_SPEED:      cfg.max_speed = pwdata[15:0];
					REG_WHEEL_RADIUS:   cfg.wheel_radius = pwdata[15:0];
					REG_CHASSIS_LENGTH: cfg.chassis_length = pwdata[15:0];
					REG_POLL_PERIOD:    cfg.poll_period_ms = pwdata[9:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				pending_poses.push_back(advance_pose(left_speed, right_speed));
			if (out_valid && out_ready) begin
				if (pending_poses.size() == 0) begin
					$error("result word with none pending: x_position %0d y_position %0d heading_angle %0d",
						x_position, y_position, heading_angle);
					mismatches++;
				end else begin
					want = pending_poses.pop_front();
					if (x_position !== want.x) begin
						$error("x_position: expected %0d, got %0d", want.x, x_position);
						mismatches++;
					end
					if (y_position !== want.y) begin
						$error("y_position: expected %0d, got %0d", want.y, y_position);
						mismatches++;
					end
					if (heading_angle !== want.hdg) begin
						$error("heading_angle: expected %0d, got %0d", want.hdg, heading_angle);
						mismatches++;
					end
				end
			end
			poses_in_flight <= pending_poses.size();
		end
	end

endmodule

### dv/differential_drive_odometry_test.sv
`timescale 1ns / 100ps
// Stimulus, clock, reset and verdict for the differential drive odometry block.
module differential_drive_odometry_test;
	import odo_regmap_pkg::*;

	localparam int CORDIC_STEPS = 16;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 400;
	localparam int PHASES       = 6;
	localparam int PHASE_WORDS  = 75;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] left_speed = '0;
	logic signed [15:0] right_speed = '0;
	logic               out_valid;
	logic               out_ready = 1'b1;
	logic signed [31:0] x_position;
	logic signed [31:0] y_position;
	logic [15:0]        heading_angle;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	int poses_in_flight;
	int mismatches;
	int cycles = 0;
	bit gaps_on = 1'b0;
	bit hold_req = 1'b0;

	differential_drive_odometry #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_speed   (left_speed),
		.right_speed  (right_speed),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.x_position   (x_position),
		.y_position   (y_position),
		.heading_angle(heading_angle),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	differential_drive_odometry_checker #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.left_speed     (left_speed),
		.right_speed    (right_speed),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.x_position     (x_position),
		.y_position     (y_position),
		.heading_angle  (heading_angle),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.poses_in_flight(poses_in_flight),
		.mismatches     (mismatches)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	// result side: short random stalls, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_word(input logic signed [15:0] l, input logic signed [15:0] r);
		left_speed <= l;
		right_speed <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic apb_write(input reg_addr_t addr, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	task automatic configure(input logic [15:0] top_speed, input logic [15:0] radius,
			input logic [15:0] chassis, input logic [9:0] period);
		in_valid <= 1'b0;
		do @(posedge clk); while (poses_in_flight != 0);
		apb_write(REG_MAX_SPEED, {16'd0, top_speed});
		apb_write(REG_WHEEL_RADIUS, {16'd0, radius});
		apb_write(REG_CHASSIS_LENGTH, {16'd0, chassis});
		apb_write(REG_POLL_PERIOD, {22'd0, period});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [15:0] pick_speed(input logic [15:0] cap);
		logic [15:0] v;
		case ($urandom_range(0, 3))
			0:       v = 16'($urandom);
			1:       v = 16'($urandom_range(0, 32767));
			default: v = 16'($urandom_range(0, cap));
		endcase
		return v;
	endfunction

	initial begin
		logic [15:0] cap, rad, chs, l, r;
		logic [9:0]  per;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gaps_on = 1'b1;

		// register defaults: zero wheel radius, no motion
		send_word(16'sd4096, 16'sd8192);
		send_word(-16'sd1, 16'sd32767);

		// all maxima, period above 1000, chassis 1 makes the turn wrap
		configure(16'hFFFF, 16'hFFFF, 16'd1, 10'd1023);
		send_word(16'sd32767, 16'sd0);
		send_word(16'sd0, 16'sd32767);
		send_word(16'sd32767, 16'sd32767);
		send_word(-16'sd32768, -16'sd32768);
		send_word(16'sh5555, 16'sh2AAA);
		send_word(16'sd1, 16'sd0);
		send_word(16'sd0, 16'sd1);

		configure(16'd4096, 16'd32768, 16'd19661, 10'd100);
		send_word(16'sd0, 16'sd0);
		send_word(16'sd4096, 16'sd4096);
		send_word(16'sd8192, 16'sd4096);
		send_word(-16'sd4096, 16'sd4096);
		send_word(16'sd4095, 16'sd4096);
		send_word(16'sd2048, 16'sd4096);
		send_word(16'sd4096, 16'sd2048);
		send_word(16'sd32767, -16'sd32768);

		// zero chassis length: no turn at all
		configure(16'd32767, 16'd65535, 16'd0, 10'd1);
		send_word(16'sd32767, 16'sd0);
		send_word(16'sd1000, 16'sd20000);

		// zero poll period and zero clamp
		configure(16'd0, 16'd65535, 16'd300, 10'd0);
		send_word(16'sd32767, 16'sd32767);
		send_word(-16'sd32768, 16'sd100);

		for (int ph = 0; ph < PHASES; ph++) begin
			gaps_on = ph < PHASES - 1;
			case ($urandom_range(0, 3))
				0:       cap = 16'hFFFF;
				1:       cap = 16'($urandom_range(0, 65535));
				default: cap = 16'($urandom_range(2048, 16384));
			endcase
			rad = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
			case ($urandom_range(0, 3))
				0:       chs = 16'($urandom_range(1, 255));
				1:       chs = 16'hFFFF;
				default: chs = 16'($urandom_range(1024, 65535));
			endcase
			per = 10'($urandom_range(1, 1023));
			configure(cap, rad, chs, per);
			if (ph == 2)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				l = pick_speed(cap);
				r = ($urandom_range(0, 7) == 0) ? l : pick_speed(cap);
				send_word(l, r);
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (poses_in_flight != 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### differential_drive_odometry.f
sv/ddodo_pkg.sv
sv/ddodo_dp.sv
sv/ddodo_ctrl.sv
sv/differential_drive_odometry.sv
dv/odo_regmap_pkg.sv
dv/differential_drive_odometry_checker.sv
dv/differential_drive_odometry_test.sv
